### sv/ccgb_pkg.sv
// Shared codes and the control/status bundles of the cross-correlogram binner.
// No dependencies.
package ccgb_pkg;

   // request commands
   localparam logic [1:0] OP_SPIKE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_MARK = 2'd1;
   localparam logic [1:0] STAT_ORDER    = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_BIN_SIZE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_BINS = 1'b1;

   localparam logic [15:0] BIN_SIZE_RESET  = 16'd1;
   localparam logic [5:0]  HALF_BINS_RESET = 6'd10;

   typedef struct packed {
      logic latch;     // take the request
      logic setup;     // edge limit, loop start, error check
      logic chk;       // capture stored spike and distance
      logic cmp;       // drop stale entry or start pairing
      logic div_step;  // one quotient bit
      logic b1_wr;     // write back count with new spike as centre
      logic b2_sel;    // address the count with stored spike as centre
      logic b2_wr;     // write back that count
      logic adv;       // next stored spike
      logic push;      // store new spike
      logic clr_step;  // one entry of the clearing sweep
      logic hrd_sel;   // address the count named by a read request
      logic hcap;      // capture read count
      logic load_rsp;  // move result to the response register
   } ccgb_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       err;
      logic       more;
      logic       stale;
      logic       b1_ok;
      logic       pair2;
      logic       div_last;
      logic       clr_last;
      logic       rsp_free;
   } ccgb_stat_type;

endpackage

### sv/ccgb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ccgb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
endmodule

### sv/ccgb_ctrl.sv
// Sequencer of the cross-correlogram binner: walks the window and the
// histogram updates for each request. Depends on ccgb_pkg.
module ccgb_ctrl import ccgb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ccgb_stat_type stat,
   output ccgb_cmd_type  cmd
);
   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_SETUP = 4'd2;
   localparam logic [3:0] ST_NEXT = 4'd3;
   localparam logic [3:0] ST_WCHK = 4'd4;
   localparam logic [3:0] ST_CMP  = 4'd5;
   localparam logic [3:0] ST_DIV  = 4'd6;
   localparam logic [3:0] ST_B1R  = 4'd7;
   localparam logic [3:0] ST_B1W  = 4'd8;
   localparam logic [3:0] ST_B2R  = 4'd9;
   localparam logic [3:0] ST_B2W  = 4'd10;
   localparam logic [3:0] ST_PUSH = 4'd11;
   localparam logic [3:0] ST_HRD  = 4'd12;
   localparam logic [3:0] ST_HCAP = 4'd13;
   localparam logic [3:0] ST_DONE = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       clr_rsp_ff, clr_rsp_in;

   always_comb begin
      state_in   = state_ff;
      clr_rsp_in = clr_rsp_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in   = clr_rsp_ff ? ST_DONE : ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (stat.op)
                  OP_SPIKE: state_in = ST_SETUP;
                  OP_READ:  state_in = ST_HRD;
                  OP_CLEAR: begin
                     state_in   = ST_CLR;
                     clr_rsp_in = 1'b1;
                  end
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = stat.err ? ST_DONE : ST_NEXT;
         end
         ST_NEXT: begin
            state_in = stat.more ? ST_WCHK : ST_PUSH;
         end
         ST_WCHK: begin
            cmd.chk  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = stat.stale ? ST_NEXT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_B1R;
            end
         end
         ST_B1R: begin
            state_in = stat.b1_ok ? ST_B1W : ST_B2R;
         end
         ST_B1W: begin
            cmd.b1_wr = 1'b1;
            state_in  = ST_B2R;
         end
         ST_B2R: begin
            cmd.b2_sel = 1'b1;
            if (stat.pair2) begin
               state_in = ST_B2W;
            end else begin
               cmd.adv  = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_B2W: begin
            cmd.b2_wr = 1'b1;
            cmd.adv   = 1'b1;
            state_in  = ST_NEXT;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_DONE;
         end
         ST_HRD: begin
            cmd.hrd_sel = 1'b1;
            state_in    = ST_HCAP;
         end
         ST_HCAP: begin
            cmd.hcap = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end
endmodule

### sv/ccgb_datapath.sv
// Datapath of the cross-correlogram binner: registers, spike window,
// histogram memory, bit-serial bin divider. Depends on ccgb_pkg, ccgb_ram.
module ccgb_datapath import ccgb_pkg::*; #(
   parameter int MAX_UNITS     = 16,
   parameter int MAX_HALF_BINS = 32,
   parameter int WINDOW_DEPTH  = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ccgb_cmd_type            cmd,
   output ccgb_stat_type           stat,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [1:0]              req_command,
   input  logic [31:0]             req_spike_time,
   input  logic [4:0]              req_unit_mark,
   input  logic [4:0]              req_read_centre_unit,
   input  logic [4:0]              req_read_other_unit,
   input  logic [6:0]              req_read_bin,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             rsp_read_count,
   output logic [7:0]              rsp_pairs_added,
   output logic [1:0]              rsp_status
);
   localparam int STRIDE = 2 * MAX_HALF_BINS + 1;
   localparam int ROW    = MAX_UNITS * STRIDE;
   localparam int HD     = MAX_UNITS * ROW;
   localparam int HAW    = HD > 1 ? $clog2(HD) : 1;
   localparam int HW     = $clog2(MAX_HALF_BINS + 2);
   localparam int BW     = $clog2(2 * MAX_HALF_BINS + 2);
   localparam int CW     = HW > 1 ? $clog2(HW) : 1;
   localparam int LW     = 17 + HW;
   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int FW     = $clog2(WINDOW_DEPTH + 1);

   // configuration
   logic [15:0] bin_size_ff;
   logic [5:0]  half_bins_ff;

   // latched request
   logic [1:0]  op_unused_ff;
   logic [31:0] t_ff;
   logic [4:0]  mark_ff, rc_ff, ro_ff;
   logic [6:0]  rb_ff;
   logic [15:0] b_ff;
   logic [HW-1:0] h_ff;
   logic [LW-1:0] lim_ff;

   // window bookkeeping
   logic [AW-1:0] head_ff, rp_ff;
   logic [FW-1:0] fill_ff, fill0_ff, k_ff;
   logic [31:0]   last_time_ff;
   logic [FW:0]   tail_wide;
   logic [36:0]   win_rdata;

   // pair work
   logic [32:0]   twod_ff;
   logic [4:0]    om_ff;
   logic [33:0]   rem_ff, dsh_ff;
   logic [HW-1:0] q_ff;
   logic [CW-1:0] dcnt_ff;
   logic [HW:0]   q2;
   logic          ge;

   // histogram
   logic [HAW-1:0] clr_addr_ff, haddr_ff, pair_addr, rd_addr, hraddr, hwaddr;
   logic [31:0]    hrdata, inc;
   logic           h_we, rd_ok;
   logic [4:0]     pc, po;
   logic [BW-1:0]  pbin;

   // results
   logic [31:0] cnt_ff;
   logic [7:0]  pairs_ff;
   logic [1:0]  stat_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_cnt_ff;
   logic [7:0]  rsp_pairs_ff;
   logic [1:0]  rsp_stat_ff;

   logic        bad_mark, out_order;
   logic [8:0]  pairs_sum;
   logic [5:0]  h_cfg;

   function automatic logic [HAW-1:0] hist_addr(input logic [4:0] c, input logic [4:0] o,
                                               input logic [BW-1:0] bin);
      logic [31:0] a;
      a = 32'(c - 5'd1) * 32'(ROW) + 32'(o - 5'd1) * 32'(STRIDE) + 32'(bin);
      return HAW'(a);
   endfunction

   // ---------------- status ----------------
   assign bad_mark  = (mark_ff == 5'd0) || (7'(mark_ff) > 7'(MAX_UNITS));
   assign out_order = t_ff < last_time_ff;
   assign ge        = rem_ff >= dsh_ff;
   assign q2        = (HW+1)'(q_ff) + (HW+1)'(rem_ff == (34'({b_ff, 1'b0}) - 34'd1));

   always_comb begin
      stat          = '0;
      stat.op       = req_command;
      stat.err      = bad_mark || out_order;
      stat.more     = k_ff < fill0_ff;
      stat.stale    = 34'(twod_ff) > 34'(lim_ff);
      stat.pair2    = 34'(twod_ff) < 34'(lim_ff);
      stat.b1_ok    = q_ff <= h_ff;
      stat.div_last = dcnt_ff == '0;
      stat.clr_last = clr_addr_ff == HAW'(HD - 1);
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff  <= BIN_SIZE_RESET;
         half_bins_ff <= HALF_BINS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_BIN_SIZE:  bin_size_ff  <= csr_wdata;
            REG_HALF_BINS: half_bins_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign h_cfg = half_bins_ff;

   // ---------------- request, loop and divider ----------------
   assign tail_wide = (head_ff >= AW'(fill_ff)) && (fill_ff < FW'(WINDOW_DEPTH))
                      ? (FW+1)'(head_ff) - (FW+1)'(fill_ff)
                      : (FW+1)'(head_ff) + (FW+1)'(WINDOW_DEPTH) - (FW+1)'(fill_ff);
   assign pairs_sum = 9'(pairs_ff) + (stat.pair2 ? 9'd2 : 9'd1);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_unused_ff <= req_command;
         t_ff         <= req_spike_time;
         mark_ff      <= req_unit_mark;
         rc_ff        <= req_read_centre_unit;
         ro_ff        <= req_read_other_unit;
         rb_ff        <= req_read_bin;
         b_ff         <= (bin_size_ff == 16'd0) ? 16'd1 : bin_size_ff;
         h_ff         <= (10'(h_cfg) > 10'(MAX_HALF_BINS)) ? HW'(MAX_HALF_BINS) : HW'(h_cfg);
         cnt_ff       <= '0;
         pairs_ff     <= '0;
         stat_ff      <= STAT_OK;
      end
      if (cmd.setup) begin
         lim_ff   <= LW'(b_ff) * LW'({h_ff, 1'b1});
         k_ff     <= '0;
         fill0_ff <= fill_ff;
         rp_ff    <= AW'(tail_wide);
         if (bad_mark) begin
            stat_ff <= STAT_BAD_MARK;
         end else if (out_order) begin
            stat_ff <= STAT_ORDER;
         end
      end
      if (cmd.chk) begin
         twod_ff <= {t_ff - win_rdata[31:0], 1'b0};
         om_ff   <= win_rdata[36:32];
      end
      if (cmd.cmp && !stat.stale) begin
         rem_ff   <= 34'(twod_ff) + 34'(b_ff) - 34'd1;
         dsh_ff   <= 34'({b_ff, 1'b0}) << (HW - 1);
         q_ff     <= '0;
         dcnt_ff  <= CW'(HW - 1);
         pairs_ff <= pairs_sum[8] ? 8'hFF : pairs_sum[7:0];
      end
      if (cmd.div_step) begin
         rem_ff  <= ge ? rem_ff - dsh_ff : rem_ff;
         dsh_ff  <= dsh_ff >> 1;
         q_ff    <= HW'({q_ff, ge});
         dcnt_ff <= dcnt_ff - CW'(1);
      end
      if (cmd.adv || (cmd.cmp && stat.stale)) begin
         k_ff  <= k_ff + FW'(1);
         rp_ff <= (rp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      end
      if (!(cmd.b1_wr || cmd.b2_wr)) begin
         haddr_ff <= pair_addr;
      end
      if (cmd.push && fill_ff >= FW'(WINDOW_DEPTH)) begin
         stat_ff <= STAT_OVERFLOW;
      end
      if (cmd.hcap) begin
         cnt_ff <= rd_ok ? hrdata : 32'd0;
      end
   end

   // window state and clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         last_time_ff <= '0;
         clr_addr_ff  <= '0;
      end else if (cmd.clr_step) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         last_time_ff <= '0;
         clr_addr_ff  <= stat.clr_last ? '0 : clr_addr_ff + HAW'(1);
      end else if (cmd.cmp && stat.stale) begin
         fill_ff <= fill_ff - FW'(1);
      end else if (cmd.push) begin
         head_ff      <= (head_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         fill_ff      <= (fill_ff >= FW'(WINDOW_DEPTH)) ? FW'(WINDOW_DEPTH)
                                                        : fill_ff + FW'(1);
         last_time_ff <= t_ff;
      end
   end

   ccgb_ram #(.WIDTH(37), .DEPTH(WINDOW_DEPTH)) u_win (
      .clock    (clock),
      .we       (cmd.push),
      .waddr    (head_ff),
      .wdata    ({mark_ff, t_ff}),
      .raddr    (rp_ff),
      .rdata_ff (win_rdata)
   );

   // ---------------- histogram ----------------
   assign pc   = cmd.b2_sel ? om_ff : mark_ff;
   assign po   = cmd.b2_sel ? mark_ff : om_ff;
   assign pbin = cmd.b2_sel ? BW'((HW+1)'(h_ff) + q2) : BW'(h_ff - q_ff);
   assign pair_addr = hist_addr(pc, po, pbin);

   assign rd_ok = (rc_ff != 5'd0) && (7'(rc_ff) <= 7'(MAX_UNITS)) &&
                  (ro_ff != 5'd0) && (7'(ro_ff) <= 7'(MAX_UNITS)) &&
                  (10'(rb_ff) < 10'(STRIDE));
   assign rd_addr = hist_addr(rc_ff, ro_ff, BW'(rb_ff));

   assign hraddr = cmd.hrd_sel ? rd_addr : pair_addr;
   assign inc    = (hrdata == 32'hFFFF_FFFF) ? hrdata : hrdata + 32'd1;
   assign h_we   = cmd.clr_step || cmd.b1_wr || cmd.b2_wr;
   assign hwaddr = cmd.clr_step ? clr_addr_ff : haddr_ff;

   ccgb_ram #(.WIDTH(32), .DEPTH(HD)) u_hist (
      .clock    (clock),
      .we       (h_we),
      .waddr    (hwaddr),
      .wdata    (cmd.clr_step ? 32'd0 : inc),
      .raddr    (hraddr),
      .rdata_ff (hrdata)
   );

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_cnt_ff   <= cnt_ff;
         rsp_pairs_ff <= (op_unused_ff == OP_SPIKE) ? pairs_ff : 8'd0;
         rsp_stat_ff  <= stat_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_count  = rsp_cnt_ff;
   assign rsp_pairs_added = rsp_pairs_ff;
   assign rsp_status      = rsp_stat_ff;
endmodule

### sv/cross_correlogram_binner_unit.sv
// Top level of the spike cross-correlogram binner.
// Depends on ccgb_pkg, ccgb_ctrl, ccgb_datapath (and through it ccgb_ram).

// Builds cross-correlogram counts per (centre unit, other unit, bin) from
// time-sorted spike requests. One request is handled at a time; its result
// sits in a response register, so the next request is taken while that
// result waits. An accepted spike visits each stored spike in the window,
// and each one in reach goes through the bit-serial bin divider, with
// HW = clog2(MAX_HALF_BINS+2) quotient bits, and then does up to two
// read-modify-writes on the histogram memory. A stale stored spike is
// dropped without either.
// After reset and on every clear request the histogram is swept to zero,
// one entry a cycle, during which no request is accepted; csr writes are
// always taken.
module cross_correlogram_binner_unit import ccgb_pkg::*; #(
   parameter int MAX_UNITS     = 16,
   parameter int MAX_HALF_BINS = 32,
   parameter int WINDOW_DEPTH  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // requests
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   input  logic [31:0]            req_spike_time,
   input  logic [4:0]             req_unit_mark,
   input  logic [4:0]             req_read_centre_unit,
   input  logic [4:0]             req_read_other_unit,
   input  logic [6:0]             req_read_bin,
   // responses
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_read_count,
   output logic [7:0]             rsp_pairs_added,
   output logic [1:0]             rsp_status
);
   ccgb_cmd_type  cmd;
   ccgb_stat_type stat;

   // sequencer: one request at a time
   ccgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // window ring, divider, histogram memory, response register
   ccgb_datapath #(
      .MAX_UNITS     (MAX_UNITS),
      .MAX_HALF_BINS (MAX_HALF_BINS),
      .WINDOW_DEPTH  (WINDOW_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_command          (req_command),
      .req_spike_time       (req_spike_time),
      .req_unit_mark        (req_unit_mark),
      .req_read_centre_unit (req_read_centre_unit),
      .req_read_other_unit  (req_read_other_unit),
      .req_read_bin         (req_read_bin),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_count       (rsp_read_count),
      .rsp_pairs_added      (rsp_pairs_added),
      .rsp_status           (rsp_status)
   );
endmodule

### bench/tb_cross_correlogram_binner_unit.sv
// Self-checking bench for cross_correlogram_binner_unit: directed and random
// spike, read, clear and unused requests against an in-bench correlogram model.
// Depends on ccgb_pkg and the RTL of the binner.
`timescale 1ns / 1ps

module tb_cross_correlogram_binner_unit;
   import ccgb_pkg::*;

   localparam int UNITS      = 16;
   localparam int HALF_MAX   = 32;
   localparam int RING_DEPTH = 64;
   localparam int BIN_STRIDE = 2 * HALF_MAX + 1;
   localparam int HIST_SIZE  = UNITS * UNITS * BIN_STRIDE;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  command;
      logic [31:0] spike_time;
      logic [4:0]  unit_mark;
      logic [4:0]  centre;
      logic [4:0]  other;
      logic [6:0]  bin;
   } request_type;

   typedef struct {
      logic [31:0] read_count;
      logic [7:0]  pairs_added;
      logic [1:0]  status;
   } response_type;

   // ---------------------------------------------------------------- signals
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_command = '0;
   logic [31:0]            req_spike_time = '0;
   logic [4:0]             req_unit_mark = '0;
   logic [4:0]             req_read_centre_unit = '0;
   logic [4:0]             req_read_other_unit = '0;
   logic [6:0]             req_read_bin = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [31:0]            rsp_read_count;
   logic [7:0]             rsp_pairs_added;
   logic [1:0]             rsp_status;

   cross_correlogram_binner_unit dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_spike_time(req_spike_time), .req_unit_mark(req_unit_mark),
      .req_read_centre_unit(req_read_centre_unit),
      .req_read_other_unit(req_read_other_unit), .req_read_bin(req_read_bin),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_count(rsp_read_count),
      .rsp_pairs_added(rsp_pairs_added), .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------- model state
   logic [15:0] cfg_bin_size;
   logic [5:0]  cfg_half_bins;
   logic [31:0] ring_time [RING_DEPTH];
   logic [4:0]  ring_mark [RING_DEPTH];
   int unsigned ring_head, ring_fill;
   logic [31:0] latest_time;
   logic [31:0] ccg_count [HIST_SIZE];

   request_type  pending_requests[$];
   response_type expected_responses[$];
   request_type  cur_request;
   int        mismatch_count = 0;
   bit        req_taken = 1'b0, rsp_taken = 1'b0;
   bit        burst_mode = 1'b0;   // no idling on either side while set
   int        send_gap = 0, recv_stall = 0;

   // generator bookkeeping (time of the last spike the block will keep)
   logic [63:0] gen_time;

   task automatic clear_correlogram();
      for (int i = 0; i < HIST_SIZE; i++) ccg_count[i] = '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_time[i] = '0;
         ring_mark[i] = '0;
      end
      ring_head   = 0;
      ring_fill   = 0;
      latest_time = '0;
   endtask

   // saturating increment, out-of-range addresses are dropped
   task automatic bump_count(input int unsigned c, input int unsigned o,
                             input int unsigned b);
      int unsigned idx;
      if (c < 1 || c > UNITS || o < 1 || o > UNITS || b >= BIN_STRIDE) return;
      idx = ((c - 1) * UNITS + (o - 1)) * BIN_STRIDE + b;
      if (ccg_count[idx] != 32'hFFFF_FFFF) ccg_count[idx] = ccg_count[idx] + 1;
   endtask

   // Computes the response of one request and advances the model.
   task automatic correlate_request(input request_type r, output response_type res);
      logic [63:0] bsz, lim, twod, q;
      int unsigned h, pairs, slot, s, idx;
      res = '{default: '0};
      pairs = 0;
      case (r.command)
         OP_SPIKE: begin
            bsz = (cfg_bin_size == 0) ? 64'd1 : 64'(cfg_bin_size);
            h   = (cfg_half_bins > HALF_MAX) ? HALF_MAX : cfg_half_bins;
            lim = bsz * (2 * 64'(h) + 1);
            if (r.unit_mark == 0 || r.unit_mark > UNITS) begin
               res.status = STAT_BAD_MARK;
            end else if (r.spike_time < latest_time) begin
               res.status = STAT_ORDER;
            end else begin
               // drop stale spikes from the old end
               while (ring_fill > 0) begin
                  slot = (ring_head + RING_DEPTH - ring_fill) % RING_DEPTH;
                  if (2 * 64'(r.spike_time - ring_time[slot]) <= lim) break;
                  ring_fill--;
               end
               slot = (ring_head + RING_DEPTH - ring_fill) % RING_DEPTH;
               for (int k = 0; k < ring_fill; k++) begin
                  s    = (slot + k) % RING_DEPTH;
                  twod = 2 * 64'(r.spike_time - ring_time[s]);
                  if (twod <= lim) begin
                     q = (twod + bsz - 1) / (2 * bsz);
                     if (q <= h) bump_count(r.unit_mark, ring_mark[s], h - q);
                     pairs++;
                  end
                  if (twod < lim) begin
                     q = (twod + bsz) / (2 * bsz);
                     bump_count(ring_mark[s], r.unit_mark, h + q);
                     pairs++;
                  end
               end
               if (ring_fill >= RING_DEPTH) begin
                  ring_fill  = RING_DEPTH - 1;
                  res.status = STAT_OVERFLOW;
               end
               ring_time[ring_head] = r.spike_time;
               ring_mark[ring_head] = r.unit_mark;
               ring_head   = (ring_head + 1) % RING_DEPTH;
               ring_fill++;
               latest_time = r.spike_time;
               res.pairs_added = (pairs > 255) ? 8'd255 : 8'(pairs);
            end
         end
         OP_READ: begin
            if (r.centre >= 1 && r.centre <= UNITS && r.other >= 1 && r.other <= UNITS
                && r.bin < BIN_STRIDE) begin
               idx = ((r.centre - 1) * UNITS + (r.other - 1)) * BIN_STRIDE + r.bin;
               res.read_count = ccg_count[idx];
            end
         end
         OP_CLEAR: clear_correlogram();
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            cur_request = pending_requests.pop_front();
            req_command          <= cur_request.command;
            req_spike_time       <= cur_request.spike_time;
            req_unit_mark        <= cur_request.unit_mark;
            req_read_centre_unit <= cur_request.centre;
            req_read_other_unit  <= cur_request.other;
            req_read_bin         <= cur_request.bin;
            req_valid            <= 1'b1;
            send_gap = burst_mode ? 0 : $urandom_range(0, 19);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: a random stall before each response is taken
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) recv_stall = burst_mode ? 0 : $urandom_range(0, 19);
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      response_type want;
      req_taken = req_valid && req_ready && !reset;
      rsp_taken = rsp_valid && rsp_ready && !reset;
      if (req_taken) begin
         correlate_request(cur_request, want);
         expected_responses.push_back(want);
      end
      if (rsp_taken) begin
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response with no request outstanding", $realtime);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_read_count !== want.read_count || rsp_pairs_added !== want.pairs_added
                || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: expected count %0d pairs %0d status %0d, got %0d %0d %0d",
                           $realtime, want.read_count, want.pairs_added, want.status,
                           rsp_read_count, rsp_pairs_added, rsp_status);
            end
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic push_request(input logic [1:0] cmd, input logic [31:0] t,
                               input logic [4:0] mark, input logic [4:0] c,
                               input logic [4:0] o, input logic [6:0] b);
      request_type r;
      r = '{command: cmd, spike_time: t, unit_mark: mark, centre: c, other: o, bin: b};
      pending_requests.push_back(r);
   endtask

   // good spike at a time that moves forward by up to the given span
   task automatic push_spike(input logic [63:0] span, input logic [4:0] mark);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)      gen_time += 64'($urandom_range(0, 2));
      else if (pick < 85) gen_time += {$urandom, $urandom} % (span + 1);
      else                gen_time += {$urandom, $urandom} % (16 * span + 1);
      if (gen_time > 64'hFFFF_FFFF) gen_time = 64'hFFFF_FFFF;
      push_request(OP_SPIKE, gen_time[31:0], mark, 5'($urandom), 5'($urandom),
                   7'($urandom));
   endtask

   // block is idle: nothing queued, nothing in flight, then a short pause
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      if (idx == REG_BIN_SIZE) cfg_bin_size = data;
      else                     cfg_half_bins = data[5:0];
      @(negedge clock);
      csr_we    = 1'b0;
      csr_wdata = 16'($urandom);
   endtask

   // one random phase under the current registers, starting from a clear
   task automatic random_phase(input int n_items, input logic [31:0] base);
      logic [63:0] lim;
      int unsigned pick, h;
      push_request(OP_CLEAR, $urandom, 5'($urandom), 5'($urandom), 5'($urandom),
                   7'($urandom));
      gen_time = base;
      h = (cfg_half_bins > HALF_MAX) ? HALF_MAX : cfg_half_bins;
      for (int i = 0; i < n_items; i++) begin
         lim  = ((cfg_bin_size == 0) ? 64'd1 : 64'(cfg_bin_size)) * (2 * h + 1);
         pick = $urandom_range(0, 999);
         if (pick < 700) begin
            push_spike(lim >> $urandom_range(1, 8), 5'($urandom_range(1, UNITS)));
         end else if (pick < 740) begin
            push_request(OP_SPIKE, $urandom, ($urandom_range(0, 1) ? 5'd0
                         : 5'($urandom_range(UNITS + 1, 31))), 5'($urandom),
                         5'($urandom), 7'($urandom));
         end else if (pick < 780) begin
            // earlier than the last kept spike, when one can be
            if (gen_time > 0)
               push_request(OP_SPIKE, gen_time[31:0] - $urandom_range(1, 64'(gen_time) > 1000
                            ? 1000 : gen_time[31:0]), 5'($urandom_range(1, UNITS)),
                            5'($urandom), 5'($urandom), 7'($urandom));
         end else if (pick < 950) begin
            push_request(OP_READ, $urandom, 5'($urandom), 5'($urandom_range(1, UNITS)),
                         5'($urandom_range(1, UNITS)), 7'($urandom_range(0, 2 * h)));
         end else if (pick < 985) begin
            push_request(OP_READ, $urandom, 5'($urandom), 5'($urandom), 5'($urandom),
                         7'($urandom));
         end else if (pick < 995) begin
            push_request(OP_UNUSED, $urandom, 5'($urandom), 5'($urandom), 5'($urandom),
                         7'($urandom));
         end else begin
            push_request(OP_CLEAR, $urandom, 5'($urandom), 5'($urandom), 5'($urandom),
                         7'($urandom));
            gen_time = 0;
         end
         // switch between idling and back-to-back stretches
         if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
      end
      wait_idle();
   endtask

   initial begin
      cfg_bin_size  = BIN_SIZE_RESET;
      cfg_half_bins = HALF_BINS_RESET;
      clear_correlogram();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset registers, bad marks, order, reads out of range
      push_request(OP_SPIKE, 32'd100, 5'd1, 5'd0, 5'd0, 7'd0);
      push_request(OP_SPIKE, 32'd103, 5'd16, 5'd31, 5'd31, 7'd127);
      push_request(OP_SPIKE, 32'd103, 5'd1, 5'd0, 5'd0, 7'd0);
      push_request(OP_SPIKE, 32'd104, 5'd0, 5'd0, 5'd0, 7'd0);
      push_request(OP_SPIKE, 32'd104, 5'd17, 5'd0, 5'd0, 7'd0);
      push_request(OP_SPIKE, 32'd104, 5'd31, 5'd0, 5'd0, 7'd0);
      push_request(OP_SPIKE, 32'd50, 5'd2, 5'd0, 5'd0, 7'd0);
      push_request(OP_READ, 32'd0, 5'd0, 5'd1, 5'd16, 7'd7);
      push_request(OP_READ, 32'd0, 5'd0, 5'd16, 5'd1, 7'd13);
      push_request(OP_READ, 32'd0, 5'd0, 5'd1, 5'd1, 7'd10);
      push_request(OP_READ, 32'd0, 5'd0, 5'd0, 5'd1, 7'd10);
      push_request(OP_READ, 32'd0, 5'd0, 5'd17, 5'd31, 7'd10);
      push_request(OP_READ, 32'd0, 5'd0, 5'd1, 5'd16, 7'd65);
      push_request(OP_READ, 32'd0, 5'd0, 5'd1, 5'd16, 7'd127);
      push_request(OP_UNUSED, 32'hFFFF_FFFF, 5'd31, 5'd31, 5'd31, 7'd127);
      push_request(OP_CLEAR, 32'd0, 5'd0, 5'd0, 5'd0, 7'd0);
      push_request(OP_READ, 32'd0, 5'd0, 5'd1, 5'd16, 7'd7);
      wait_idle();

      // zero bin size and too many half bins
      write_csr(REG_BIN_SIZE, 16'd0);
      write_csr(REG_HALF_BINS, 16'hFFFF);
      push_request(OP_SPIKE, 32'd10, 5'd3, 5'd0, 5'd0, 7'd0);
      push_request(OP_SPIKE, 32'd42, 5'd4, 5'd0, 5'd0, 7'd0);
      push_request(OP_SPIKE, 32'd43, 5'd3, 5'd0, 5'd0, 7'd0);
      push_request(OP_READ, 32'd0, 5'd0, 5'd4, 5'd3, 7'd0);
      push_request(OP_READ, 32'd0, 5'd0, 5'd3, 5'd4, 7'd64);
      wait_idle();

      // widest bins near the top of the time range: the ring overflows
      write_csr(REG_BIN_SIZE, 16'hFFFF);
      write_csr(REG_HALF_BINS, 16'd32);
      push_request(OP_CLEAR, 32'd0, 5'd0, 5'd0, 5'd0, 7'd0);
      for (int i = 0; i < 70; i++)
         push_request(OP_SPIKE, 32'hFFFF_FF00 + 32'(i), 5'(i % UNITS + 1), 5'd0, 5'd0, 7'd0);
      push_request(OP_READ, 32'd0, 5'd0, 5'd1, 5'd2, 7'd32);
      wait_idle();

      // random idling on both sides, then random phases
      burst_mode = 1'b0;
      random_phase(240, 32'd0);
      write_csr(REG_BIN_SIZE, 16'd1);
      write_csr(REG_HALF_BINS, 16'd0);
      random_phase(200, 32'h8000_0000);
      write_csr(REG_BIN_SIZE, 16'd7);
      write_csr(REG_HALF_BINS, 16'd5);
      random_phase(240, 32'h0000_1000);
      write_csr(REG_BIN_SIZE, 16'hFFFF);
      write_csr(REG_HALF_BINS, 16'hFFE0 | 16'd32);
      random_phase(200, 32'hF000_0000);
      write_csr(REG_BIN_SIZE, 16'hAAAA);
      write_csr(REG_HALF_BINS, 16'd63);
      random_phase(160, 32'd0);
      // registers changed mid-stream with the ring kept
      write_csr(REG_BIN_SIZE, 16'h5555);
      write_csr(REG_HALF_BINS, 16'd21);
      for (int i = 0; i < 40; i++) push_spike(64'h1_0000, 5'($urandom_range(1, UNITS)));
      for (int i = 0; i < 20; i++)
         push_request(OP_READ, $urandom, 5'($urandom), 5'($urandom_range(1, UNITS)),
                      5'($urandom_range(1, UNITS)), 7'($urandom_range(0, 42)));
      wait_idle();
      repeat (50) @(posedge clock);

      if (mismatch_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #80_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
